### design/arpt_pkg.sv
// ARP address table: shared widths, opcodes and the stored entry layout.
// No dependencies.
package arpt_pkg;

   localparam int OPCODE_W          = 2;
   localparam int IP_W              = 32;
   localparam int MAC_W             = 48;
   localparam int TABLE_ENTRIES_DEF = 16;

   localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;

   typedef struct packed {
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } entry_type;

   localparam int ENTRY_W = IP_W + MAC_W;

endpackage

### design/arpt_if.sv
// Valid/ready channels of the ARP address table: request and response words.
// Depends on arpt_pkg.
interface arpt_req_if;
   logic                           valid;
   logic                           ready;
   logic [arpt_pkg::OPCODE_W-1:0]  opcode;
   logic [arpt_pkg::IP_W-1:0]      lookup_ip;
   logic [arpt_pkg::MAC_W-1:0]     new_mac;

   modport source (output valid, output opcode, output lookup_ip, output new_mac,
                   input ready);
   modport sink   (input valid, input opcode, input lookup_ip, input new_mac,
                   output ready);
endinterface

interface arpt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [arpt_pkg::MAC_W-1:0]  found_mac;

   modport source (output valid, output hit, output found_mac, input ready);
   modport sink   (input valid, input hit, input found_mac, output ready);
endinterface

### design/arpt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module arpt_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [WIDTH-1:0]      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/arpt_seq.sv
// ARP address table sequencer: entry valid bits, table scan, slot choice and
// response register. Depends on arpt_pkg and arpt_if; drives an arpt_ram.
module arpt_seq #(
   parameter int  TABLE_ENTRIES = arpt_pkg::TABLE_ENTRIES_DEF,
   localparam int AW            = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   arpt_req_if.sink                       req,
   arpt_rsp_if.source                     rsp,
   output logic [AW-1:0]                  ram_rd_addr,
   input  logic [arpt_pkg::ENTRY_W-1:0]   ram_rd_data,
   output logic                           ram_wr_en,
   output logic [AW-1:0]                  ram_wr_addr,
   output logic [arpt_pkg::ENTRY_W-1:0]   ram_wr_data
);
   localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_REPLY
   } state_type;

   state_type                       state_ff;
   logic [TABLE_ENTRIES-1:0]        valid_ff;
   logic [AW-1:0]                   rd_addr_ff;
   logic                            chk_vld_ff;
   logic [AW-1:0]                   chk_idx_ff;
   logic [arpt_pkg::OPCODE_W-1:0]   op_ff;
   logic [arpt_pkg::IP_W-1:0]       ip_ff;
   logic [arpt_pkg::MAC_W-1:0]      mac_ff;
   logic                            hit_ff;
   logic [arpt_pkg::MAC_W-1:0]      found_ff;
   logic                            free_ff;
   logic [AW-1:0]                   slot_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_hit_ff;
   logic [arpt_pkg::MAC_W-1:0]      rsp_mac_ff;

   arpt_pkg::entry_type             rd_entry;
   logic                            match;
   logic                            still_valid;
   logic                            rsp_free;

   assign rd_entry    = arpt_pkg::entry_type'(ram_rd_data);
   assign match       = chk_vld_ff && valid_ff[chk_idx_ff] && (rd_entry.ip == ip_ff);
   assign still_valid = valid_ff[chk_idx_ff] && !match;
   assign rsp_free    = !rsp_valid_ff || rsp.ready;

   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.hit       = rsp_hit_ff;
   assign rsp.found_mac = rsp_mac_ff;

   assign ram_rd_addr = rd_addr_ff;
   assign ram_wr_en   = (state_ff == ST_WRITE);
   assign ram_wr_addr = slot_ff;
   assign ram_wr_data = {ip_ff, mac_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_addr_ff   <= '0;
      end else begin
         chk_vld_ff <= (state_ff == ST_SCAN);
         chk_idx_ff <= rd_addr_ff;

         // in ST_REPLY the response register is reloaded below instead
         if (rsp_valid_ff && rsp.ready && state_ff != ST_REPLY) begin
            rsp_valid_ff <= 1'b0;
         end

         // compare stage, one entry behind the read address
         if (chk_vld_ff) begin
            if (match && op_ff != arpt_pkg::OP_INSERT) begin
               hit_ff <= 1'b1;
            end
            if (match && op_ff == arpt_pkg::OP_LOOKUP && !hit_ff) begin
               found_ff <= rd_entry.mac;
            end
            if (match && op_ff != arpt_pkg::OP_LOOKUP) begin
               valid_ff[chk_idx_ff] <= 1'b0;
            end
            // first slot left free after this word's deletes
            if (!still_valid && !free_ff) begin
               free_ff <= 1'b1;
               slot_ff <= chk_idx_ff;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               rd_addr_ff <= '0;
               if (req.valid) begin
                  op_ff    <= req.opcode;
                  ip_ff    <= req.lookup_ip;
                  mac_ff   <= req.new_mac;
                  hit_ff   <= 1'b0;
                  found_ff <= '0;
                  free_ff  <= 1'b0;
                  slot_ff  <= '0;
                  if (req.opcode == arpt_pkg::OP_LOOKUP ||
                      req.opcode == arpt_pkg::OP_INSERT ||
                      req.opcode == arpt_pkg::OP_DELETE) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_REPLY;
                  end
               end
            end
            ST_SCAN: begin
               if (rd_addr_ff == LAST_IDX) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  rd_addr_ff <= rd_addr_ff + AW'(1);
               end
            end
            ST_DRAIN: begin
               state_ff <= (op_ff == arpt_pkg::OP_INSERT) ? ST_WRITE : ST_REPLY;
            end
            ST_WRITE: begin
               valid_ff[slot_ff] <= 1'b1;
               state_ff          <= ST_REPLY;
            end
            ST_REPLY: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= hit_ff;
                  rsp_mac_ff   <= found_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### design/arp_address_table.sv
// ARP address table top level: sequencer plus the IP/MAC entry RAM.
// Depends on arpt_pkg, arpt_if, arpt_ram and arpt_seq.
//
// Usage:
//   req_chan carries one request word: opcode (lookup, insert, delete),
//   lookup_ip and new_mac. rsp_chan returns exactly one response word per
//   request: hit and found_mac, in request order.
//   Each lookup, insert or delete scans every table entry through the RAM
//   read port, one entry per cycle, then an insert writes its slot.
//   A request passes the scan, a drain state, for an insert the slot
//   write, and the reply state to its response word; the next request is
//   taken the cycle after the response is loaded, so a new request is not
//   accepted while one is in progress. The scan over the single RAM read
//   port bounds the request rate. An unused opcode skips the scan and replies.
//   Reset clears all entry valid bits at once; no clearing pass.
//   The response sits in an output register; a new request is accepted
//   while it waits, and a finished request holds until the register frees.
module arp_address_table #(
   parameter int TABLE_ENTRIES = arpt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   arpt_req_if.sink      req_chan,
   arpt_rsp_if.source    rsp_chan
);
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic [AW-1:0]                 ram_rd_addr;
   logic [arpt_pkg::ENTRY_W-1:0]  ram_rd_data;
   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_wr_addr;
   logic [arpt_pkg::ENTRY_W-1:0]  ram_wr_data;

   arpt_seq #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   arpt_ram #(
      .WIDTH (arpt_pkg::ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
